// File: rtl/box_region_table_core_assert.svh
// Assertion macros used by the checker in rtl/brt_checker.sv.
`ifndef BOX_REGION_TABLE_CORE_ASSERT_SVH
`define BOX_REGION_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/brt_pkg.sv
`default_nettype none
package brt_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int ENTRIES_W    = 6;

   // Command codes.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_POINT  = 2'd2;
   localparam logic [1:0] CMD_BOX    = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // One stored box, laid out as the request data word.
   typedef struct packed {
      logic [15:0] hz;
      logic [15:0] hy;
      logic [15:0] hx;
      logic [15:0] lz;
      logic [15:0] ly;
      logic [15:0] lx;
      logic [31:0] id;
   } slot_type;

   // Per-cell update controls.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: rtl/box_region_table_core.sv
`default_nettype none
// Ordered table of 3D boxes with insert, remove, point and box queries.
// Request channel req_*: one command per transfer; tuser carries the command
// and the overlap flag, tdata the id and both corners.
// Result channel rsp_*: insert and remove give one transfer; a query gives one
// transfer per matching box in table order, or one miss transfer with hit
// clear. tlast marks the final transfer of a command.
// Sequence: a command is taken in the idle state, all cells compare in the next
// cycle in the exec state, and insert or remove update the row of cells and
// load their result into the result register there, waiting while a stalled
// result is held. A query then drains its match vector one transfer per cycle
// while the receiver takes them, through the single result register.
// Reset empties the table (fill count zero) and drops any pending result.
// When the receiver stalls, the result is held and the sequencer waits; no
// new request is taken until the last result of the current command has
// been loaded into the result register.
module box_region_table_core #(
   parameter int CAPACITY = brt_pkg::CAPACITY_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,  // area_id, low_x, low_y, low_z, high_x, high_y, high_z
   input  wire  [2:0]   req_tuser,  // cmd, overlap mode
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [39:0]  rsp_tdata,  // match_id, entries, zero fill
   output logic [2:0]   rsp_tuser,  // status, hit
   output logic         rsp_tlast
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   brt_pkg::slot_type req_ff;
   logic [1:0] cmd_ff;
   logic ovl_ff;
   logic [CAPACITY-1:0] mv_ff, mv_in;

   logic rv_ff, rv_in;
   logic [1:0] rst_ff, rst_in;
   logic rhit_ff, rhit_in, rlast_ff, rlast_in;
   logic [31:0] rid_ff, rid_in;
   logic [brt_pkg::ENTRIES_W-1:0] rent_ff, rent_in;

   brt_pkg::slot_type q [CAPACITY];
   brt_pkg::cell_ctl_type ctl [CAPACITY];
   logic [CAPACITY-1:0] eqv, hitv, pre, onehot, rest;
   logic found, full, out_free, accept;
   logic [31:0] sel_id;

   // Row of cells, each handing its box to the left neighbor on removal.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic eq_raw, hit_raw;
      brt_cell u_cell (
         .clock   (clock),
         .ctl     (ctl[i]),
         .req     (req_ff),
         .cmd     (cmd_ff),
         .overlap (ovl_ff),
         .nxt     ((i == CAPACITY - 1) ? q[i] : q[(i + 1) % CAPACITY]),
         .q       (q[i]),
         .id_eq   (eq_raw),
         .box_hit (hit_raw)
      );
      assign eqv[i]  = eq_raw && (CNT_W'(i) < cnt_ff);
      assign hitv[i] = hit_raw && (CNT_W'(i) < cnt_ff);
      if (i == 0) begin : g_pre0
         assign pre[i] = eqv[i];
      end else begin : g_pre
         assign pre[i] = pre[i-1] | eqv[i];
      end
   end

   assign found    = |eqv;
   assign full     = (cnt_ff == CNT_W'(CAPACITY));
   assign out_free = !rv_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept   = req_tvalid && req_tready;

   // Lowest pending match and its id.
   always_comb begin
      onehot = mv_ff & (~mv_ff + CAPACITY'(1));
      rest   = mv_ff & ~onehot;
      sel_id = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (onehot[i]) begin
            sel_id = sel_id | q[i].id;
         end
      end
   end

   // Sequencer and cell controls.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mv_in    = mv_ff;
      rv_in    = rv_ff && !rsp_tready;
      rst_in   = rst_ff;
      rhit_in  = rhit_ff;
      rlast_in = rlast_ff;
      rid_in   = rid_ff;
      rent_in  = rent_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         ctl[i] = '0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rst_in   = brt_pkg::ST_DONE;
               rhit_in  = 1'b0;
               rlast_in = 1'b1;
               rid_in   = '0;
               state_in = S_IDLE;
               if (cmd_ff == brt_pkg::CMD_INSERT) begin
                  if (found) begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        ctl[i].load = eqv[i];
                     end
                  end else if (full) begin
                     rst_in = brt_pkg::ST_FULL;
                  end else begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        ctl[i].load = (cnt_ff == CNT_W'(i));
                     end
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end else if (cmd_ff == brt_pkg::CMD_REMOVE) begin
                  if (found) begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        ctl[i].shift = pre[i];
                     end
                     cnt_in = cnt_ff - CNT_W'(1);
                  end else begin
                     rst_in = brt_pkg::ST_NOTFOUND;
                  end
               end else if (|hitv) begin
                  rv_in    = rv_ff && !rsp_tready;
                  mv_in    = hitv;
                  state_in = S_DRAIN;
               end
               rent_in = brt_pkg::ENTRIES_W'(cnt_in);
            end
         end
         S_DRAIN: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rst_in   = brt_pkg::ST_DONE;
               rhit_in  = 1'b1;
               rid_in   = sel_id;
               rlast_in = (rest == '0);
               rent_in  = brt_pkg::ENTRIES_W'(cnt_ff);
               mv_in    = rest;
               if (rest == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_tdata;
         cmd_ff <= req_tuser[1:0];
         ovl_ff <= req_tuser[2];
      end
      mv_ff    <= mv_in;
      rst_ff   <= rst_in;
      rhit_ff  <= rhit_in;
      rlast_ff <= rlast_in;
      rid_ff   <= rid_in;
      rent_ff  <= rent_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {2'b00, rent_ff, rid_ff};
   assign rsp_tuser  = {rhit_ff, rst_ff};
   assign rsp_tlast  = rlast_ff;

endmodule
`default_nettype wire

// File: rtl/brt_cell.sv
`default_nettype none
module brt_cell (
   input  wire                   clock,
   input  brt_pkg::cell_ctl_type ctl,
   input  brt_pkg::slot_type     req,
   input  wire  [1:0]            cmd,
   input  wire                   overlap,
   input  brt_pkg::slot_type     nxt,
   output brt_pkg::slot_type     q,
   output logic                  id_eq,
   output logic                  box_hit
);

   brt_pkg::slot_type slot_ff;
   logic in_pt, in_box, ovl;

   // Storage: load from the request, or take the neighbor's box on removal.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         slot_ff <= req;
      end else if (ctl.shift) begin
         slot_ff <= nxt;
      end
   end

   assign q     = slot_ff;
   assign id_eq = (slot_ff.id == req.id);

   // Geometric tests against the broadcast request.
   always_comb begin
      in_pt  = ($signed(slot_ff.lx) <= $signed(req.lx)) && ($signed(req.lx) <= $signed(slot_ff.hx))
            && ($signed(slot_ff.ly) <= $signed(req.ly)) && ($signed(req.ly) <= $signed(slot_ff.hy))
            && ($signed(slot_ff.lz) <= $signed(req.lz)) && ($signed(req.lz) <= $signed(slot_ff.hz));
      in_box = ($signed(req.lx) <= $signed(slot_ff.lx)) && ($signed(slot_ff.hx) <= $signed(req.hx))
            && ($signed(req.ly) <= $signed(slot_ff.ly)) && ($signed(slot_ff.hy) <= $signed(req.hy))
            && ($signed(req.lz) <= $signed(slot_ff.lz)) && ($signed(slot_ff.hz) <= $signed(req.hz));
      ovl    = ($signed(slot_ff.lx) <= $signed(req.hx)) && ($signed(req.lx) <= $signed(slot_ff.hx))
            && ($signed(slot_ff.ly) <= $signed(req.hy)) && ($signed(req.ly) <= $signed(slot_ff.hy))
            && ($signed(slot_ff.lz) <= $signed(req.hz)) && ($signed(req.lz) <= $signed(slot_ff.hz));
      if (cmd == brt_pkg::CMD_POINT) begin
         box_hit = in_pt;
      end else begin
         box_hit = in_box || (overlap && ovl);
      end
   end

endmodule
`default_nettype wire

// File: rtl/brt_checker.sv
`default_nettype none
`include "box_region_table_core_assert.svh"
module brt_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [39:0]  rsp_tdata,
   input wire [2:0]   rsp_tuser,
   input wire         rsp_tlast
);

   // A stalled result stays offered.
   `BRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Only a query match may be followed by more transfers of the same command.
   `BRT_ASSERT_IMPLY(a_more_hit, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser[2])
   // An error ends the command and carries no match.
   `BRT_ASSERT_IMPLY(a_err_last, clock, reset,
      rsp_tvalid && (rsp_tuser[1:0] != brt_pkg::ST_DONE), rsp_tlast && !rsp_tuser[2])
   // A miss carries a zero id.
   `BRT_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[2],
      rsp_tdata[31:0] == 32'd0)
   // Requests are taken one at a time: ready drops after each one is taken.
   `BRT_ASSERT_NEXT(a_req_gap, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind box_region_table_core brt_checker u_brt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// File: tb/sv/box_region_table_core_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module box_region_table_core_checker #(
   parameter int CAPACITY = brt_pkg::CAPACITY_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   input  wire          req_tready,
   input  wire  [127:0] req_tdata,
   input  wire  [2:0]   req_tuser,
   input  wire          rsp_tvalid,
   input  wire          rsp_tready,
   input  wire  [39:0]  rsp_tdata,
   input  wire  [2:0]   rsp_tuser,
   input  wire          rsp_tlast,
   output int           fail_count,
   output int           pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [31:0] match_id;
      logic        last;
      logic [5:0]  entries;
   } answer_type;

   // Shadow copy of the box table.
   logic [31:0]        shadow_id [CAPACITY];
   logic signed [15:0] shadow_lo [CAPACITY][3];
   logic signed [15:0] shadow_hi [CAPACITY][3];
   int                 shadow_fill;
   answer_type         answers [$];

   assign pending = answers.size();

   function automatic int locate_id(logic [31:0] id);
      for (int i = 0; i < shadow_fill; i++)
         if (shadow_id[i] == id) return i;
      return -1;
   endfunction

   function automatic answer_type make_answer(logic [1:0] st, logic h,
                                              logic [31:0] id, logic l);
      answer_type a;
      a.status = st;
      a.hit = h;
      a.match_id = id;
      a.last = l;
      a.entries = 6'(shadow_fill);
      return a;
   endfunction

   // Append one expected result at the tail of the queue.
   task automatic queue_answer(answer_type a);
      answers.insert(answers.size(), a);
   endtask

   // Apply one command to the shadow table and queue the results it causes.
   task automatic apply_command(logic [1:0] cmd, logic ovl, logic [127:0] d);
      logic [31:0]        id;
      logic signed [15:0] lo [3];
      logic signed [15:0] hi [3];
      int                 pos;
      bit                 inbox, over, any;
      id = d[31:0];
      for (int a = 0; a < 3; a++) begin
         lo[a] = d[32 + 16 * a +: 16];
         hi[a] = d[80 + 16 * a +: 16];
      end
      case (cmd)
         brt_pkg::CMD_INSERT: begin
            pos = locate_id(id);
            if (pos < 0 && shadow_fill >= CAPACITY) begin
               queue_answer(make_answer(brt_pkg::ST_FULL, 1'b0, '0, 1'b1));
            end else begin
               if (pos < 0) begin
                  pos = shadow_fill;
                  shadow_fill++;
               end
               shadow_id[pos] = id;
               for (int a = 0; a < 3; a++) begin
                  shadow_lo[pos][a] = lo[a];
                  shadow_hi[pos][a] = hi[a];
               end
               queue_answer(make_answer(brt_pkg::ST_DONE, 1'b0, '0, 1'b1));
            end
         end
         brt_pkg::CMD_REMOVE: begin
            pos = locate_id(id);
            if (pos < 0) begin
               queue_answer(make_answer(brt_pkg::ST_NOTFOUND, 1'b0, '0, 1'b1));
            end else begin
               for (int i = pos; i + 1 < shadow_fill; i++) begin
                  shadow_id[i] = shadow_id[i + 1];
                  shadow_lo[i] = shadow_lo[i + 1];
                  shadow_hi[i] = shadow_hi[i + 1];
               end
               shadow_fill--;
               queue_answer(make_answer(brt_pkg::ST_DONE, 1'b0, '0, 1'b1));
            end
         end
         default: begin
            any = 0;
            for (int i = 0; i < shadow_fill; i++) begin
               inbox = 1;
               over = 1;
               for (int a = 0; a < 3; a++) begin
                  if (cmd == brt_pkg::CMD_POINT) begin
                     if (!(shadow_lo[i][a] <= lo[a] && lo[a] <= shadow_hi[i][a]))
                        inbox = 0;
                  end else begin
                     if (!(lo[a] <= shadow_lo[i][a] && shadow_hi[i][a] <= hi[a]))
                        inbox = 0;
                     if (!(shadow_lo[i][a] <= hi[a] && lo[a] <= shadow_hi[i][a]))
                        over = 0;
                  end
               end
               if (inbox || (cmd == brt_pkg::CMD_BOX && ovl && over)) begin
                  // The last flag of the previous hit is cleared below.
                  if (any) answers[$].last = 1'b0;
                  queue_answer(make_answer(brt_pkg::ST_DONE, 1'b1, shadow_id[i], 1'b1));
                  any = 1;
               end
            end
            if (!any) queue_answer(make_answer(brt_pkg::ST_DONE, 1'b0, '0, 1'b1));
         end
      endcase
   endtask

   // Watch both channels and compare each result transfer.
   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         shadow_fill = 0;
         answers.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser[1:0];
            got.hit = rsp_tuser[2];
            got.match_id = rsp_tdata[31:0];
            got.last = rsp_tlast;
            got.entries = rsp_tdata[37:32];
            if (answers.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (got !== want) begin
                  $display("%0t: expected %0d/%0d/%h/%0d/%0d, actual %0d/%0d/%h/%0d/%0d",
                     $time, want.status, want.hit, want.match_id, want.last, want.entries,
                     got.status, got.hit, got.match_id, got.last, got.entries);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_command(req_tuser[1:0], req_tuser[2], req_tdata);
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/box_region_table_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module box_region_table_core_tb;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // area_id, low_x, low_y, low_z, high_x, high_y, high_z
   logic [2:0]   req_tuser = '0;  // cmd, overlap mode
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [39:0]  rsp_tdata;       // match_id, entries, zero fill
   logic [2:0]   rsp_tuser;       // status, hit
   logic         rsp_tlast;
   int           fail_count;
   int           pending;
   bit           calm = 0;

   box_region_table_core dut (.*);

   box_region_table_core_checker watch (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver side stalls at random except during the calm stretch.
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 35);

   // Pick an id from a small pool so that replaces and removals find matches.
   function automatic logic [31:0] pick_id();
      case ($urandom_range(9))
         0: return 32'hFFFF_FFFF;
         1: return $urandom();
         default: return 32'(1000 + $urandom_range(39));
      endcase
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom());
         default: return 16'(-200 + $urandom_range(400));
      endcase
   endfunction

   // Send one command over the request channel, with an optional idle gap.
   task automatic send(logic [1:0] cmd, logic ovl, logic [31:0] id,
                       logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                       logic [15:0] hx, logic [15:0] hy, logic [15:0] hz);
      while (!calm && $urandom_range(99) < 35) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= {ovl, cmd};
      req_tdata <= {hz, hy, hx, lz, ly, lx, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random box with mostly ordered corners; some stay inverted.
   task automatic send_random(logic [1:0] cmd);
      logic [15:0] l [3];
      logic [15:0] h [3];
      logic [15:0] t;
      for (int a = 0; a < 3; a++) begin
         l[a] = pick_coord();
         h[a] = pick_coord();
         if ($signed(l[a]) > $signed(h[a]) && $urandom_range(9) != 0) begin
            t = l[a];
            l[a] = h[a];
            h[a] = t;
         end
      end
      send(cmd, 1'($urandom_range(1)), pick_id(), l[0], l[1], l[2], h[0], h[1], h[2]);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty-table cases, extremes, fill to full, overflow, replace.
      send(brt_pkg::CMD_REMOVE, 1'b0, 32'd5, '0, '0, '0, '0, '0, '0);
      send(brt_pkg::CMD_POINT, 1'b0, '0, '0, '0, '0, '0, '0, '0);
      send(brt_pkg::CMD_INSERT, 1'b0, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000,
           16'h7FFF, 16'h7FFF, 16'h7FFF);
      send(brt_pkg::CMD_INSERT, 1'b0, 32'd0, 16'd10, 16'd10, 16'd10,
           16'd20, 16'd20, 16'd20);
      send(brt_pkg::CMD_INSERT, 1'b0, 32'd7, 16'd5, 16'd5, 16'd5,
           -16'sd5, 16'd9, 16'd9);
      send(brt_pkg::CMD_POINT, 1'b0, '0, 16'd15, 16'd15, 16'd15, '0, '0, '0);
      send(brt_pkg::CMD_POINT, 1'b0, '0, 16'h7FFF, 16'h8000, 16'h7FFF, '0, '0, '0);
      send(brt_pkg::CMD_BOX, 1'b0, '0, 16'd0, 16'd0, 16'd0, 16'd30, 16'd30, 16'd30);
      send(brt_pkg::CMD_BOX, 1'b1, '0, 16'd15, 16'd15, 16'd15, 16'd30, 16'd30, 16'd30);
      send(brt_pkg::CMD_BOX, 1'b1, '0, 16'd21, 16'd21, 16'd21, 16'd30, 16'd30, 16'd30);
      send(brt_pkg::CMD_INSERT, 1'b0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
      send(brt_pkg::CMD_REMOVE, 1'b0, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
      for (int i = 0; i < 31; i++)
         send(brt_pkg::CMD_INSERT, 1'b0, 32'(100 + i), -16'sd50, -16'sd50, -16'sd50,
              16'd50, 16'd50, 16'd50);
      send(brt_pkg::CMD_INSERT, 1'b0, 32'd999, '0, '0, '0, '0, '0, '0);
      send(brt_pkg::CMD_INSERT, 1'b0, 32'd105, '0, '0, '0, 16'd1, 16'd1, 16'd1);
      send(brt_pkg::CMD_POINT, 1'b0, '0, '0, '0, '0, '0, '0, '0);
      send(brt_pkg::CMD_REMOVE, 1'b0, 32'd100, '0, '0, '0, '0, '0, '0);
      for (int i = 1; i < 31; i++)
         send(brt_pkg::CMD_REMOVE, 1'b0, 32'(100 + i), '0, '0, '0, '0, '0, '0);
      send(brt_pkg::CMD_REMOVE, 1'b0, 32'd0, '0, '0, '0, '0, '0, '0);
      req_tvalid <= 0;

      // Let every expected result drain before the random part.
      @(posedge clock);
      wait (pending == 0);

      // Random traffic, with a calm stretch in the middle.
      for (int n = 0; n < 330; n++) begin
         calm = (n >= 150 && n < 220);
         case ($urandom_range(9))
            0, 1, 2, 3: send_random(brt_pkg::CMD_INSERT);
            4, 5:       send_random(brt_pkg::CMD_REMOVE);
            6, 7:       send_random(brt_pkg::CMD_POINT);
            default:    send_random(brt_pkg::CMD_BOX);
         endcase
      end
      calm = 0;
      req_tvalid <= 0;

      @(posedge clock);
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire
